// ----- rtl/slt_pkg.sv -----
// slt_pkg: shared types and constants of the sta/lta event trigger
// field widths, fixed-point constants, register indexes, config and result structs
// no dependencies
package slt_pkg;

   localparam int SAMPLE_W  = 24;   // width of the sample field on the bus
   localparam int PEAK_W    = 24;   // width of the reported peak
   localparam int FRAC_BITS = 8;    // fractional bits of the averages
   localparam int AVG_FLOOR = 256;  // lowest value the long average may take
   localparam int SHIFT_W   = 4;
   localparam int RATIO_W   = 4;
   localparam int LEVEL_W   = 24;
   localparam int WARM_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_SHIFT  = 3'd0,
      CSR_LONG_SHIFT   = 3'd1,
      CSR_ON_RATIO     = 3'd2,
      CSR_OFF_RATIO    = 3'd3,
      CSR_STRONG_LEVEL = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [SHIFT_W-1:0] short_shift;
      logic [SHIFT_W-1:0] long_shift;
      logic [RATIO_W-1:0] on_ratio;
      logic [RATIO_W-1:0] off_ratio;
      logic [LEVEL_W-1:0] strong_level;
   } cfg_type;

   typedef struct packed {
      logic              strong_res;
      logic [PEAK_W-1:0] peak;
      logic              occurred;
   } res_type;

endpackage

// ----- rtl/sta_lta_event_trigger_core.sv -----
// sta_lta_event_trigger_core: top level of the short/long average event trigger
// depends on slt_pkg, slt_front, slt_track (and slt_avg below it)
//
// one signed sample in per req beat, exactly one result out per rsp beat, in order.
// each sample is rectified, scaled by 256 and folded into a short and a long
// exponential average (floor shifts, long average floored at 256, frozen during an
// event, both seeded from the first sample). after 2^long_shift warm-up samples an
// event opens when short > long*on_ratio and closes when short < long*off_ratio;
// the closing beat reports occurred=1, the event peak and whether it reaches
// strong_level, all other beats carry zeros. throughput is one sample per clock while
// rsp keeps up; a sample passes the input register holding the rectified magnitude,
// then the result register. the clock period is set by the state loop: average
// update (subtract, shift, add, floor) feeding the ratio product and compare. the
// input side keeps taking beats while a result waits on rsp, so a stall costs
// nothing until both registers are full. no memories, no clearing pass: the block
// is ready straight out of reset. csr writes take effect at once and are meant to
// be made while no sample is in flight.
module sta_lta_event_trigger_core #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // [23:0] sample
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,  // [0] occurred, [24:1] peak,
                                                         // [25] strong_res, rest zero
   // register writes
   input  logic                              csr_we,
   input  logic [slt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [slt_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   slt_pkg::cfg_type        cfg_ff;
   slt_pkg::res_type        res;
   slt_pkg::res_type        rsp_data_ff;
   logic                    rsp_valid_ff;
   logic                    front_valid;
   logic                    out_en;
   logic                    step_en;
   logic [SAMPLE_BITS-1:0]  mag;

   // result register free, or being emptied this cycle
   assign out_en  = !rsp_valid_ff || rsp_tready;
   assign step_en = front_valid && out_en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_shift  <= slt_pkg::SHIFT_W'(3);
         cfg_ff.long_shift   <= slt_pkg::SHIFT_W'(8);
         cfg_ff.on_ratio     <= slt_pkg::RATIO_W'(4);
         cfg_ff.off_ratio    <= slt_pkg::RATIO_W'(2);
         cfg_ff.strong_level <= slt_pkg::LEVEL_W'(100000);
      end else if (csr_we) begin
         unique case (csr_index)
            slt_pkg::CSR_SHORT_SHIFT:  cfg_ff.short_shift  <= csr_wdata[slt_pkg::SHIFT_W-1:0];
            slt_pkg::CSR_LONG_SHIFT:   cfg_ff.long_shift   <= csr_wdata[slt_pkg::SHIFT_W-1:0];
            slt_pkg::CSR_ON_RATIO:     cfg_ff.on_ratio     <= csr_wdata[slt_pkg::RATIO_W-1:0];
            slt_pkg::CSR_OFF_RATIO:    cfg_ff.off_ratio    <= csr_wdata[slt_pkg::RATIO_W-1:0];
            slt_pkg::CSR_STRONG_LEVEL: cfg_ff.strong_level <= csr_wdata[slt_pkg::LEVEL_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   // input register with rectifier
   slt_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .sample    (req_tdata),
      .out_valid (front_valid),
      .out_ready (out_en),
      .mag       (mag)
   );

   // averages, warm-up and event state
   slt_track #(.SAMPLE_BITS(SAMPLE_BITS)) u_track (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .mag     (mag),
      .cfg     (cfg_ff),
      .res     (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

`ifndef SYNTHESIS
   // a result without an event end carries no peak and no strong flag
   a_quiet_beat_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.occurred |->
         (rsp_data_ff.peak == '0) && !rsp_data_ff.strong_res)
      else $error("result without event end carries peak or strong flag");

   // a sample moving out of the input register lands in the result register
   a_step_lands: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff)
      else $error("processed sample did not reach the result register");

   // input side only stalls when both registers are occupied and the result is not taken
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> front_valid && rsp_valid_ff && !rsp_tready)
      else $error("input stalled with room in the pipeline");

   // the result register never moves while it is held
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_data_ff))
      else $error("result register changed while stalled");
`endif

endmodule

// ----- rtl/slt_front.sv -----
// slt_front: input stage, rectifies the sample and holds its magnitude
// depends on slt_pkg
module slt_front #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [slt_pkg::SAMPLE_W-1:0]  sample,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [SAMPLE_BITS-1:0]        mag
);

   logic                   valid_ff;
   logic [SAMPLE_BITS-1:0] mag_ff;
   logic [SAMPLE_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0] rect;

   // bits above SAMPLE_BITS are ignored; most negative value maps onto itself
   assign raw      = sample[SAMPLE_BITS-1:0];
   assign rect     = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mag_ff <= rect;
      end
   end

   assign out_valid = valid_ff;
   assign mag       = mag_ff;

endmodule

// ----- rtl/slt_avg.sv -----
// slt_avg: one step of an exponential average with floor shift and optional floor
// depends on slt_pkg
module slt_avg #(
   parameter int AVG_W = 32
) (
   input  logic [AVG_W-1:0]            avg_cur,
   input  logic [AVG_W-1:0]            target,
   input  logic [slt_pkg::SHIFT_W-1:0] shift,
   input  logic                        floor_en,
   output logic [AVG_W-1:0]            avg_next
);

   logic signed [AVG_W:0] diff;
   logic signed [AVG_W:0] step;
   logic signed [AVG_W:0] sum;

   always_comb begin
      diff = signed'({1'b0, target}) - signed'({1'b0, avg_cur});
      step = diff >>> shift;   // arithmetic shift rounds towards minus infinity
      sum  = signed'({1'b0, avg_cur}) + step;
      if (floor_en && (sum < signed'((AVG_W+1)'(slt_pkg::AVG_FLOOR)))) begin
         avg_next = AVG_W'(slt_pkg::AVG_FLOOR);
      end else begin
         avg_next = sum[AVG_W-1:0];
      end
   end

endmodule

// ----- rtl/slt_track.sv -----
// slt_track: average state, warm-up counter and event tracking
// depends on slt_pkg and slt_avg
module slt_track #(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic [SAMPLE_BITS-1:0]  mag,
   input  slt_pkg::cfg_type        cfg,
   output slt_pkg::res_type        res
);

   localparam int AVG_W  = SAMPLE_BITS + slt_pkg::FRAC_BITS;
   localparam int PROD_W = AVG_W + slt_pkg::RATIO_W;

   logic [AVG_W-1:0]              short_ff, short_in;
   logic [AVG_W-1:0]              long_ff, long_in;
   logic [SAMPLE_BITS-1:0]        peak_ff, peak_in;
   logic                          event_ff, event_in;
   logic                          primed_ff;
   logic [slt_pkg::WARM_W-1:0]    warm_ff, warm_in;

   logic [AVG_W-1:0]              scaled;
   logic [AVG_W-1:0]              seed_long;
   logic [AVG_W-1:0]              cur_short, cur_long;
   logic [AVG_W-1:0]              long_step;
   logic [PROD_W-1:0]             prod_on, prod_off, short_ext;
   logic [SAMPLE_BITS-1:0]        peak_max;
   logic [slt_pkg::WARM_W-1:0]    warm_limit;
   logic                          warming;

   assign scaled    = {mag, slt_pkg::FRAC_BITS'(0)};
   assign seed_long = (scaled < AVG_W'(slt_pkg::AVG_FLOOR)) ? AVG_W'(slt_pkg::AVG_FLOOR)
                                                             : scaled;
   // first sample after reset seeds both averages
   assign cur_short = primed_ff ? short_ff : scaled;
   assign cur_long  = primed_ff ? long_ff  : seed_long;

   slt_avg #(.AVG_W(AVG_W)) u_short (
      .avg_cur  (cur_short),
      .target   (scaled),
      .shift    (cfg.short_shift),
      .floor_en (1'b0),
      .avg_next (short_in)
   );

   slt_avg #(.AVG_W(AVG_W)) u_long (
      .avg_cur  (cur_long),
      .target   (scaled),
      .shift    (cfg.long_shift),
      .floor_en (1'b1),
      .avg_next (long_step)
   );

   // long average frozen while an event is open
   assign long_in    = event_ff ? cur_long : long_step;
   assign short_ext  = PROD_W'(short_in);
   assign prod_on    = PROD_W'(long_in) * PROD_W'(cfg.on_ratio);
   assign prod_off   = PROD_W'(long_in) * PROD_W'(cfg.off_ratio);
   assign peak_max   = (mag > peak_ff) ? mag : peak_ff;
   assign warm_limit = slt_pkg::WARM_W'(1) << cfg.long_shift;
   assign warming    = warm_ff < warm_limit;
   assign warm_in    = warming ? (warm_ff + slt_pkg::WARM_W'(1)) : warm_ff;

   always_comb begin
      event_in = event_ff;
      peak_in  = peak_ff;
      res      = '0;
      if (!warming) begin
         if (!event_ff) begin
            if (short_ext > prod_on) begin
               event_in = 1'b1;
               peak_in  = mag;
            end
         end else begin
            peak_in = peak_max;
            if (short_ext < prod_off) begin
               event_in       = 1'b0;
               res.occurred   = 1'b1;
               res.peak       = slt_pkg::PEAK_W'(peak_max);
               res.strong_res = slt_pkg::LEVEL_W'(peak_max) >= cfg.strong_level;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff  <= '0;
         long_ff   <= AVG_W'(slt_pkg::AVG_FLOOR);
         peak_ff   <= '0;
         event_ff  <= 1'b0;
         primed_ff <= 1'b0;
         warm_ff   <= '0;
      end else if (step_en) begin
         short_ff  <= short_in;
         long_ff   <= long_in;
         peak_ff   <= peak_in;
         event_ff  <= event_in;
         primed_ff <= 1'b1;
         warm_ff   <= warm_in;
      end
   end

endmodule

// ----- verif/tb_sta_lta_event_trigger_core.sv -----
// tb_sta_lta_event_trigger_core: self-checking bench for the sta/lta event trigger core
// drives sample beats and register writes, predicts every result beat and compares it
// depends on slt_pkg and sta_lta_event_trigger_core only
module tb_sta_lta_event_trigger_core;
   timeunit 1ns;
   timeprecision 1ps;

   // spare register index, writes to it must leave every register alone
   localparam logic [slt_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam slt_pkg::res_type NO_EVENT = '0;
   localparam int NUM_PHASES  = 8;
   localparam int CALM_PHASE  = 4;     // phase run with no idling on either side
   localparam int PHASE_BEATS = 110;
   localparam int LAST_BEATS  = 60;    // long warm-up phase, no decisions possible

   // one row of the directed part: either a register write or a sample beat
   typedef struct packed {
      logic                           is_write;
      logic [slt_pkg::CSR_IDX_W-1:0]  idx;
      logic [slt_pkg::CSR_DATA_W-1:0] value;   // register data or sample
      logic                           typed;   // result given in the row, not by the predictor
      slt_pkg::res_type               want;
   } step_row_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [23:0]                    req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [31:0]                    rsp_tdata;
   logic                           csr_we     = 1'b0;
   logic [slt_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [slt_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // predictor state, mirrors the block after reset
   slt_pkg::cfg_type cfg_shadow;
   longint  sta_acc;          // short-term average, 8 fractional bits
   longint  lta_acc;          // long-term average, floored at AVG_FLOOR
   logic [slt_pkg::PEAK_W-1:0] event_peak;
   bit      event_open;
   bit      seeded;
   int      warm_count;

   slt_pkg::res_type due_results [$];   // expected result beats, oldest first
   step_row_type     directed_rows [$];
   int           mismatch_count = 0;
   int           rsp_beat_no    = 0;
   int           req_idle_pct   = 14;
   int           rsp_idle_pct   = 14;

   // quiet/burst pattern for the random part
   int burst_left = 0;
   bit burst_loud = 1'b1;
   int burst_amp  = 1;

   always #6 clock = ~clock;

   sta_lta_event_trigger_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [23:0] sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [0] occurred, [24:1] peak, [25] strong_res, rest zero
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // result side back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s, result beat %0d: got %0h, want %0h",
               what, rsp_beat_no, got, want);
      mismatch_count++;
   endtask

   // rectify, update both averages, then open or close an event
   function automatic slt_pkg::res_type predict_trigger(
      input logic [slt_pkg::SAMPLE_W-1:0] raw);
      logic [slt_pkg::PEAK_W-1:0] mag;
      longint                     scaled;
      slt_pkg::res_type           r;
      r      = NO_EVENT;
      mag    = raw[slt_pkg::SAMPLE_W-1] ? -raw : raw;   // most negative rectifies to 2^23
      scaled = longint'(mag) << slt_pkg::FRAC_BITS;
      if (!seeded) begin
         sta_acc = scaled;
         lta_acc = (scaled < longint'(slt_pkg::AVG_FLOOR)) ? longint'(slt_pkg::AVG_FLOOR)
                                                            : scaled;
         seeded  = 1'b1;
      end
      // arithmetic shift of a signed value is the floor division
      sta_acc += (scaled - sta_acc) >>> cfg_shadow.short_shift;
      if (!event_open) begin
         lta_acc += (scaled - lta_acc) >>> cfg_shadow.long_shift;
         if (lta_acc < longint'(slt_pkg::AVG_FLOOR))
            lta_acc = longint'(slt_pkg::AVG_FLOOR);
      end
      // warm-up compares against the current long shift, so it may resume
      if (warm_count < (32'd1 << cfg_shadow.long_shift)) begin
         warm_count++;
         return r;
      end
      if (!event_open) begin
         if (sta_acc > lta_acc * longint'(cfg_shadow.on_ratio)) begin
            event_open = 1'b1;
            event_peak = mag;
         end
      end else begin
         if (mag > event_peak)
            event_peak = mag;
         if (sta_acc < lta_acc * longint'(cfg_shadow.off_ratio)) begin
            event_open   = 1'b0;
            r.occurred   = 1'b1;
            r.peak       = event_peak;
            r.strong_res = (event_peak >= cfg_shadow.strong_level);
         end
      end
      return r;
   endfunction

   // alternating quiet stretches and loud bursts, with some full-range noise
   function logic [slt_pkg::SAMPLE_W-1:0] next_ground_sample();
      logic [slt_pkg::SAMPLE_W-1:0] s;
      if (burst_left == 0) begin
         burst_loud = !burst_loud;
         burst_left = burst_loud ? $urandom_range(1, 6) : $urandom_range(4, 30);
         burst_amp  = burst_loud ? (1 << $urandom_range(10, 23)) : (1 << $urandom_range(0, 6));
      end
      burst_left--;
      if ($urandom_range(0, 9) == 0)
         return slt_pkg::SAMPLE_W'($urandom);
      s = slt_pkg::SAMPLE_W'($urandom_range(0, burst_amp));
      if ($urandom_range(0, 1) == 1)
         s = -s;
      return s;
   endfunction

   function automatic step_row_type quiet(input logic [slt_pkg::SAMPLE_W-1:0] s);
      return '{is_write: 1'b0, idx: '0, value: s, typed: 1'b1, want: NO_EVENT};
   endfunction

   function automatic step_row_type pred(input logic [slt_pkg::SAMPLE_W-1:0] s);
      return '{is_write: 1'b0, idx: '0, value: s, typed: 1'b0, want: NO_EVENT};
   endfunction

   function automatic step_row_type reg_wr(input logic [slt_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [slt_pkg::CSR_DATA_W-1:0] v);
      return '{is_write: 1'b1, idx: idx, value: v, typed: 1'b0, want: NO_EVENT};
   endfunction

   // one sample beat; the expectation is queued at the accepting edge
   task automatic push_sample(input logic [slt_pkg::SAMPLE_W-1:0] s, input bit typed,
                              input slt_pkg::res_type typed_res);
      slt_pkg::res_type r;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      r = predict_trigger(s);
      due_results.push_back(typed ? typed_res : r);
   endtask

   // hold the sender until every result has come back, plus the pipeline depth
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (due_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // leaves csr_we high, the caller lowers it after the last write of a batch
   task automatic write_reg(input logic [slt_pkg::CSR_IDX_W-1:0] idx,
                            input logic [slt_pkg::CSR_DATA_W-1:0] v);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      case (idx)
         slt_pkg::CSR_SHORT_SHIFT:
            cfg_shadow.short_shift  = v[slt_pkg::SHIFT_W-1:0];
         slt_pkg::CSR_LONG_SHIFT:
            cfg_shadow.long_shift   = v[slt_pkg::SHIFT_W-1:0];
         slt_pkg::CSR_ON_RATIO:
            cfg_shadow.on_ratio     = v[slt_pkg::RATIO_W-1:0];
         slt_pkg::CSR_OFF_RATIO:
            cfg_shadow.off_ratio    = v[slt_pkg::RATIO_W-1:0];
         slt_pkg::CSR_STRONG_LEVEL:
            cfg_shadow.strong_level = v[slt_pkg::LEVEL_W-1:0];
         default: ;   // spare indexes change nothing
      endcase
   endtask

   task automatic apply_cfg(input slt_pkg::cfg_type c);
      drain_results();
      write_reg(slt_pkg::CSR_SHORT_SHIFT, slt_pkg::CSR_DATA_W'(c.short_shift));
      write_reg(slt_pkg::CSR_LONG_SHIFT, slt_pkg::CSR_DATA_W'(c.long_shift));
      write_reg(slt_pkg::CSR_ON_RATIO, slt_pkg::CSR_DATA_W'(c.on_ratio));
      write_reg(slt_pkg::CSR_OFF_RATIO, slt_pkg::CSR_DATA_W'(c.off_ratio));
      write_reg(slt_pkg::CSR_STRONG_LEVEL, c.strong_level);
      // a stray write to one of the spare indexes now and then
      if ($urandom_range(0, 1) == 1)
         write_reg(slt_pkg::CSR_IDX_W'(slt_pkg::CSR_STRONG_LEVEL + $urandom_range(1, 3)),
                   slt_pkg::CSR_DATA_W'($urandom));
      csr_we <= 1'b0;
   endtask

   // register settings per random phase, extremes spread over the phases
   function automatic slt_pkg::cfg_type phase_cfg(input int p);
      slt_pkg::cfg_type c;
      c.short_shift  = slt_pkg::SHIFT_W'($urandom_range(1, 4));
      c.long_shift   = slt_pkg::SHIFT_W'($urandom_range(1, 6));
      c.on_ratio     = slt_pkg::RATIO_W'($urandom_range(1, 4));
      c.off_ratio    = slt_pkg::RATIO_W'($urandom_range(0, 3));
      c.strong_level = slt_pkg::LEVEL_W'($urandom_range(0, 1 << 23));
      case (p)
         0: begin   // carries warm-up on to 64 samples
            c.short_shift = slt_pkg::SHIFT_W'(2);
            c.long_shift  = slt_pkg::SHIFT_W'(6);
            c.on_ratio    = slt_pkg::RATIO_W'(3);
            c.off_ratio   = slt_pkg::RATIO_W'(1);
         end
         1: begin   // anything the fields allow, on_ratio of zero included
            c.on_ratio     = slt_pkg::RATIO_W'($urandom_range(0, 15));
            c.off_ratio    = slt_pkg::RATIO_W'($urandom_range(0, 15));
            c.strong_level = slt_pkg::LEVEL_W'($urandom_range(0, 24'hFFFFFF));
         end
         2: begin   // short average follows the sample, every peak strong
            c.short_shift  = slt_pkg::SHIFT_W'(0);
            c.long_shift   = slt_pkg::SHIFT_W'(4);
            c.on_ratio     = slt_pkg::RATIO_W'(2);
            c.off_ratio    = slt_pkg::RATIO_W'(1);
            c.strong_level = '0;
         end
         3: begin   // long average follows the sample, events open on a drop
            c.short_shift = slt_pkg::SHIFT_W'(2);
            c.long_shift  = slt_pkg::SHIFT_W'(0);
            c.on_ratio    = slt_pkg::RATIO_W'(1);
            c.off_ratio   = slt_pkg::RATIO_W'(1);
         end
         4: begin   // highest start ratio, zero end ratio: events never close
            c.short_shift  = slt_pkg::SHIFT_W'(1);
            c.long_shift   = slt_pkg::SHIFT_W'(5);
            c.on_ratio     = slt_pkg::RATIO_W'(15);
            c.off_ratio    = slt_pkg::RATIO_W'(0);
            c.strong_level = slt_pkg::LEVEL_W'(1 << 23);
         end
         5: begin   // events close almost at once
            c.short_shift  = slt_pkg::SHIFT_W'(3);
            c.long_shift   = slt_pkg::SHIFT_W'(6);
            c.on_ratio     = slt_pkg::RATIO_W'(1);
            c.off_ratio    = slt_pkg::RATIO_W'(15);
            c.strong_level = '0;
         end
         6: begin   // slowest short average
            c.short_shift = slt_pkg::SHIFT_W'(15);
            c.long_shift  = slt_pkg::SHIFT_W'(3);
            c.on_ratio    = slt_pkg::RATIO_W'(2);
            c.off_ratio   = slt_pkg::RATIO_W'(1);
         end
         default: begin   // warm-up resumes towards 2^15, no decisions
            c.short_shift  = slt_pkg::SHIFT_W'($urandom_range(1, 15));
            c.long_shift   = slt_pkg::SHIFT_W'(15);
            c.strong_level = '1;
         end
      endcase
      return c;
   endfunction

   // result beat checker
   always @(posedge clock) begin
      slt_pkg::res_type got;
      slt_pkg::res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = slt_pkg::res_type'(rsp_tdata[$bits(slt_pkg::res_type)-1:0]);
         if (due_results.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata, '0);
         end else begin
            want = due_results.pop_front();
            if (got.occurred !== want.occurred)
               report_mismatch("occurred", 32'(got.occurred), 32'(want.occurred));
            if (got.peak !== want.peak)
               report_mismatch("peak", 32'(got.peak), 32'(want.peak));
            if (got.strong_res !== want.strong_res)
               report_mismatch("strong_res", 32'(got.strong_res), 32'(want.strong_res));
            if (rsp_tdata[31:$bits(slt_pkg::res_type)] !== '0)
               report_mismatch("padding", rsp_tdata, '0);
         end
         rsp_beat_no++;
      end
   end

   // watchdog, far above the slowest passing run
   initial begin
      #(5_000_000);
      $display("timeout: %0d results still outstanding", due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      // register and state values out of reset
      cfg_shadow.short_shift  = slt_pkg::SHIFT_W'(3);
      cfg_shadow.long_shift   = slt_pkg::SHIFT_W'(8);
      cfg_shadow.on_ratio     = slt_pkg::RATIO_W'(4);
      cfg_shadow.off_ratio    = slt_pkg::RATIO_W'(2);
      cfg_shadow.strong_level = slt_pkg::LEVEL_W'(100000);
      sta_acc    = 0;
      lta_acc    = longint'(slt_pkg::AVG_FLOOR);
      event_peak = '0;
      event_open = 1'b0;
      seeded     = 1'b0;
      warm_count = 0;

      directed_rows = '{
         // warm-up on reset settings: zero, smallest, minus one
         quiet(24'h000000), quiet(24'h000001), quiet(24'hFFFFFF),
         // long shift cut mid warm-up, one warm-up beat left
         reg_wr(slt_pkg::CSR_LONG_SHIFT, 24'd2), reg_wr(slt_pkg::CSR_SHORT_SHIFT, 24'd1),
         reg_wr(slt_pkg::CSR_ON_RATIO, 24'd1), reg_wr(slt_pkg::CSR_OFF_RATIO, 24'd1),
         reg_wr(slt_pkg::CSR_STRONG_LEVEL, 24'h800000), reg_wr(CSR_SPARE, 24'hFFFFFF),
         quiet(24'h000002),
         // full-scale positive opens, most negative raises the peak to the threshold
         pred(24'h7FFFFF), pred(24'h800000),
         pred(24'h000000), pred(24'h000000), pred(24'h000000), pred(24'h000000),
         pred(24'h000000), pred(24'h000000),
         // second event peaking one below the strong threshold
         pred(24'h7FFFFF), pred(24'hC00000),
         pred(24'h000000), pred(24'h000000), pred(24'h000000), pred(24'h000000)
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            if (i == 0 || !directed_rows[i-1].is_write)
               drain_results();
            write_reg(directed_rows[i].idx, directed_rows[i].value);
         end else begin
            if (i > 0 && directed_rows[i-1].is_write)
               csr_we <= 1'b0;
            push_sample(directed_rows[i].value, directed_rows[i].typed,
                        directed_rows[i].want);
         end
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         apply_cfg(phase_cfg(p));
         req_idle_pct = (p == CALM_PHASE) ? 0 : 14;
         rsp_idle_pct = (p == CALM_PHASE) ? 0 : 14;
         repeat ((p == NUM_PHASES - 1) ? LAST_BEATS : PHASE_BEATS)
            push_sample(next_ground_sample(), 1'b0, NO_EVENT);
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sta_lta_event_trigger_core.f -----
rtl/slt_pkg.sv
rtl/slt_front.sv
rtl/slt_avg.sv
rtl/slt_track.sv
rtl/sta_lta_event_trigger_core.sv
verif/tb_sta_lta_event_trigger_core.sv
